[rtl/ukf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukf_pkg: shared types and constants of the unique key queue
// Field widths, action and status codes, and row and per-cell control.
// ----------------------------------------------------------------------------
package ukf_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 5;
   localparam int CNT_W    = 5;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_TAKE   = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2,
      ST_NONE = 2'd3
   } status_type;

   // queue-wide command to the row of cells
   typedef struct packed {
      logic insert;
      logic take;
   } row_ctl_type;

   // command to one cell
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage
`default_nettype wire

[rtl/ukf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukf_cell: one queue entry
// Holds a key/value pair, loads a new pair, takes its neighbour's pair on a
// take, and matches its key against the incoming key.
// ----------------------------------------------------------------------------
module ukf_cell (
   input  wire                                  clock,
   input  ukf_pkg::cell_ctl_type                ctl,
   input  wire                                  occupied,
   input  wire  signed [ukf_pkg::KEY_W-1:0]     ins_key,
   input  wire  signed [ukf_pkg::VAL_W-1:0]     ins_value,
   input  wire  signed [ukf_pkg::KEY_W-1:0]     nxt_key,
   input  wire  signed [ukf_pkg::VAL_W-1:0]     nxt_value,
   output logic signed [ukf_pkg::KEY_W-1:0]     key,
   output logic signed [ukf_pkg::VAL_W-1:0]     value,
   output logic                                 hit
);

   logic signed [ukf_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [ukf_pkg::VAL_W-1:0] value_ff, value_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.load) begin
         key_in   = ins_key;
         value_in = ins_value;
      end else if (ctl.shift) begin
         key_in   = nxt_key;
         value_in = nxt_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign hit   = occupied && (key_ff == ins_key);

endmodule
`default_nettype wire

[rtl/ukf_row.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukf_row: chain of entry cells
// Cell 0 is the head. A take shifts every cell one place towards the head;
// an insert loads the cell just past the last occupied one.
// ----------------------------------------------------------------------------
module ukf_row #(
   parameter int DEPTH = ukf_pkg::DEPTH_DEFAULT,
   parameter int CW    = $clog2(DEPTH + 1),
   parameter int IW    = $clog2(DEPTH)
) (
   input  wire                                  clock,
   input  ukf_pkg::row_ctl_type                 ctl,
   input  wire         [CW-1:0]                 count,
   input  wire  signed [ukf_pkg::KEY_W-1:0]     ins_key,
   input  wire  signed [ukf_pkg::VAL_W-1:0]     ins_value,
   input  wire         [IW-1:0]                 rd_idx,
   output logic                                 dup,
   output logic signed [ukf_pkg::KEY_W-1:0]     rd_key,
   output logic signed [ukf_pkg::VAL_W-1:0]     rd_value
);

   logic signed [ukf_pkg::KEY_W-1:0] key_arr   [DEPTH];
   logic signed [ukf_pkg::VAL_W-1:0] value_arr [DEPTH];
   logic        [DEPTH-1:0]          hit_vec;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);

      ukf_pkg::cell_ctl_type            cctl;
      logic                             occ;
      logic signed [ukf_pkg::KEY_W-1:0] nkey;
      logic signed [ukf_pkg::VAL_W-1:0] nvalue;

      assign cctl.load  = ctl.insert && (count == IDX);
      assign cctl.shift = ctl.take;
      assign occ        = IDX < count;

      if (i < DEPTH - 1) begin : g_mid
         assign nkey   = key_arr[i+1];
         assign nvalue = value_arr[i+1];
      end else begin : g_last
         // last cell falls out of range on a take, its content is dead
         assign nkey   = key_arr[i];
         assign nvalue = value_arr[i];
      end

      ukf_cell u_cell (
         .clock     (clock),
         .ctl       (cctl),
         .occupied  (occ),
         .ins_key   (ins_key),
         .ins_value (ins_value),
         .nxt_key   (nkey),
         .nxt_value (nvalue),
         .key       (key_arr[i]),
         .value     (value_arr[i]),
         .hit       (hit_vec[i])
      );
   end

   assign dup      = |hit_vec;
   assign rd_key   = key_arr[rd_idx];
   assign rd_value = value_arr[rd_idx];

endmodule
`default_nettype wire

[rtl/unique_key_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unique_key_fifo: queue of key/value pairs with unique keys
// Insert at tail (rejects duplicates and overflow), take head, read by
// 1-based position. Every response carries the resulting entry count.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)              | tuser
//  req     | in  | key, value, position, pad       | action
//  rsp     | out | out_key, out_value, count, pad  | status
//
//  One request beat per cycle while the response side is not stalled; its
//  response is registered and appears the cycle after the beat. All entries
//  sit in a chain of cells: the duplicate check compares every cell at once,
//  a take shifts the whole chain together. Reset empties the queue at once,
//  with no clearing pass. A response waiting on rsp_tready holds the
//  request side only if it is not taken in the same cycle.
// ----------------------------------------------------------------------------
module unique_key_fifo #(
   parameter int DEPTH = ukf_pkg::DEPTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // key[31:0], value[63:32], position[68:64], zero pad
   input  wire  [ukf_pkg::REQ_DATA_W-1:0]       req_tdata,
   // action[1:0]
   input  wire  [ukf_pkg::ACTION_W-1:0]         req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // out_key[31:0], out_value[63:32], count[68:64], zero pad
   output logic [ukf_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status[1:0]
   output logic [ukf_pkg::STATUS_W-1:0]         rsp_tuser
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int XW = (CW > ukf_pkg::POS_W) ? CW : ukf_pkg::POS_W;
   localparam int PAD_W = ukf_pkg::RSP_DATA_W - ukf_pkg::KEY_W - ukf_pkg::VAL_W
                          - ukf_pkg::CNT_W;

   logic                                accept;
   ukf_pkg::action_type                 action;
   logic signed [ukf_pkg::KEY_W-1:0]    in_key;
   logic signed [ukf_pkg::VAL_W-1:0]    in_value;
   logic        [ukf_pkg::POS_W-1:0]    in_pos;

   logic        [CW-1:0]                count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ukf_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic signed [ukf_pkg::KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic signed [ukf_pkg::VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic        [ukf_pkg::CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   ukf_pkg::row_ctl_type                row_ctl;
   logic                                dup;
   logic                                full;
   logic                                in_range;
   logic        [XW-1:0]                pos_x, cnt_x, rd_off, cnt_out_x;
   logic        [IW-1:0]                rd_idx;
   logic signed [ukf_pkg::KEY_W-1:0]    rd_key;
   logic signed [ukf_pkg::VAL_W-1:0]    rd_value;

   assign in_key   = req_tdata[31:0];
   assign in_value = req_tdata[63:32];
   assign in_pos   = req_tdata[68:64];
   assign action   = ukf_pkg::action_type'(req_tuser);

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign pos_x    = XW'(in_pos);
   assign cnt_x    = XW'(count_ff);
   assign in_range = (pos_x != '0) && (pos_x <= cnt_x);
   assign rd_off   = pos_x - XW'(1);
   assign full     = count_ff == CW'(DEPTH);

   always_comb begin
      row_ctl       = '0;
      count_in      = count_ff;
      rsp_status_in = ukf_pkg::ST_NONE;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rd_idx        = rd_off[IW-1:0];
      unique case (action)
         ukf_pkg::ACT_INSERT: begin
            if (dup) begin
               rsp_status_in = ukf_pkg::ST_DUP;
            end else if (full) begin
               rsp_status_in = ukf_pkg::ST_FULL;
            end else begin
               rsp_status_in  = ukf_pkg::ST_OK;
               row_ctl.insert = accept;
               count_in       = count_ff + CW'(1);
            end
         end
         ukf_pkg::ACT_TAKE: begin
            rd_idx = '0;
            if (count_ff != '0) begin
               rsp_status_in = ukf_pkg::ST_OK;
               rsp_key_in    = rd_key;
               rsp_value_in  = rd_value;
               row_ctl.take  = accept;
               count_in      = count_ff - CW'(1);
            end
         end
         ukf_pkg::ACT_READ: begin
            if (in_range) begin
               rsp_status_in = ukf_pkg::ST_OK;
               rsp_key_in    = rd_key;
               rsp_value_in  = rd_value;
            end
         end
         default: begin
         end
      endcase
   end

   assign cnt_out_x    = XW'(count_in);
   assign rsp_count_in = cnt_out_x[ukf_pkg::CNT_W-1:0];
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   ukf_row #(
      .DEPTH (DEPTH),
      .CW    (CW),
      .IW    (IW)
   ) u_row (
      .clock     (clock),
      .ctl       (row_ctl),
      .count     (count_ff),
      .ins_key   (in_key),
      .ins_value (in_value),
      .rd_idx    (rd_idx),
      .dup       (dup),
      .rd_key    (rd_key),
      .rd_value  (rd_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload, loaded with the beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_count_ff, rsp_value_ff, rsp_key_ff};

endmodule
`default_nettype wire
